### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers for the stick scaler RTL
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// same-cycle implication under synchronous reset
`define ASDZ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("asdz assertion failed");
// next-cycle implication under synchronous reset
`define ASDZ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("asdz assertion failed");
`else
`define ASDZ_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ASDZ_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

### hdl/asdz_pkg.sv
// ----------------------------------------------------------------------------
// asdz_pkg
// Types and constants for the analog stick deadzone scaler
// ----------------------------------------------------------------------------
package asdz_pkg;

  // fixed-point limits
  localparam int AXIS_MAX   = 32767;
  localparam int OUT_MAX    = 127;
  localparam int SCALE_ONE  = 65536;

  // lane pipeline depth: input, square, sum, 24 root bits, normalize,
  // 17 quotient bits, multiply, saturate check, 7 axis quotient bits
  localparam int ROOT_BITS   = 24;
  localparam int NORM_BITS   = 17;
  localparam int AXQ_BITS    = 7;
  localparam int LANE_STAGES = 3 + ROOT_BITS + 1 + NORM_BITS + 2 + AXQ_BITS;

  // register indexes
  localparam logic [1:0] CFG_DZ_LEFT     = 2'd0;
  localparam logic [1:0] CFG_DZ_RIGHT    = 2'd1;
  localparam logic [1:0] CFG_RADIAL_LEFT = 2'd2;
  localparam logic [1:0] CFG_RADIAL_RIGHT = 2'd3;

  // reset values
  localparam logic [14:0] DZ_LEFT_RST  = 15'd7849;
  localparam logic [14:0] DZ_RIGHT_RST = 15'd8689;

  typedef struct packed {
    logic signed [15:0] left_raw_x;
    logic signed [15:0] left_raw_y;
    logic signed [15:0] right_raw_x;
    logic signed [15:0] right_raw_y;
  } in_word_t;

  typedef struct packed {
    logic signed [7:0] left_out_x;
    logic signed [7:0] left_out_y;
    logic signed [7:0] right_out_x;
    logic signed [7:0] right_out_y;
    logic [16:0]       left_magnitude;
    logic [16:0]       right_magnitude;
  } out_word_t;

endpackage

### hdl/analog_stick_deadzone_scaler.sv
// ----------------------------------------------------------------------------
// analog_stick_deadzone_scaler
// Radial deadzone and rescaling for a pair of analog sticks
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall carry one word with raw X/Y of both
// sticks. Output channel: out_valid / out_stall carry the scaled axes and the
// normalized magnitudes of both sticks. Each stick runs in its own lane.
// After the edge that accepts an input word, the word passes 54 lane stages
// (input, square, sum, one per root bit, normalize setup, one per magnitude
// quotient bit, multiply, saturate check, one per axis quotient bit), the
// last of which feeds the output register that drives out_valid.
// Throughput is one word per cycle unless stalled; lanes fully pipelined.
// Write the registers through cfg_wr_en / cfg_index / cfg_data only while
// the block holds no words in flight; the block itself does not enforce this.
// Reset clears all valid flags and loads the default deadzones and modes.
// When the receiver stalls a waiting result, the whole pipeline holds and
// in_stall rises in the same cycle; it drops when the result is taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module analog_stick_deadzone_scaler (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  asdz_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output asdz_pkg::out_word_t out_word,
  input  logic                cfg_wr_en,
  input  logic [1:0]          cfg_index,
  input  logic [14:0]         cfg_data
);

  localparam int NSTG = asdz_pkg::LANE_STAGES;

  logic [14:0]     dz_left_r, dz_right_r;
  logic            radial_left_r, radial_right_r;
  logic [NSTG-1:0] vld_r;
  logic            out_valid_r;
  asdz_pkg::out_word_t out_word_r, merge_word;
  logic            en;

  // pipeline moves unless a finished word is held
  assign en        = !(out_valid_r && out_stall);
  assign in_stall  = !en;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dz_left_r      <= asdz_pkg::DZ_LEFT_RST;
      dz_right_r     <= asdz_pkg::DZ_RIGHT_RST;
      radial_left_r  <= 1'b1;
      radial_right_r <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        asdz_pkg::CFG_DZ_LEFT:      dz_left_r      <= cfg_data;
        asdz_pkg::CFG_DZ_RIGHT:     dz_right_r     <= cfg_data;
        asdz_pkg::CFG_RADIAL_LEFT:  radial_left_r  <= cfg_data[0];
        asdz_pkg::CFG_RADIAL_RIGHT: radial_right_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // stick lanes
  asdz_lane u_left (
    .clk    (clk),
    .en     (en),
    .raw_x  (in_word.left_raw_x),
    .raw_y  (in_word.left_raw_y),
    .dz     (dz_left_r),
    .radial (radial_left_r),
    .out_x  (merge_word.left_out_x),
    .out_y  (merge_word.left_out_y),
    .mag    (merge_word.left_magnitude)
  );

  asdz_lane u_right (
    .clk    (clk),
    .en     (en),
    .raw_x  (in_word.right_raw_x),
    .raw_y  (in_word.right_raw_y),
    .dz     (dz_right_r),
    .radial (radial_right_r),
    .out_x  (merge_word.right_out_x),
    .out_y  (merge_word.right_out_y),
    .mag    (merge_word.right_magnitude)
  );

  // valid chain alongside the lanes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r       <= {vld_r[NSTG-2:0], in_valid};
      out_valid_r <= vld_r[NSTG-1];
    end
  end

  // merged output word register
  always_ff @(posedge clk) begin
    if (en) begin
      out_word_r <= merge_word;
    end
  end

  // checks
  `ASDZ_ASSERT_IMP(a_stall_only_when_held, clk, rst_n, in_stall, out_valid)
  `ASDZ_ASSERT_IMP(a_mag_range, clk, rst_n, out_valid,
    out_word.left_magnitude <= 17'd65536 && out_word.right_magnitude <= 17'd65536)
  `ASDZ_ASSERT_IMP(a_axis_range, clk, rst_n, out_valid,
    out_word.left_out_x != 8'h80 && out_word.left_out_y != 8'h80 &&
    out_word.right_out_x != 8'h80 && out_word.right_out_y != 8'h80)
  `ASDZ_ASSERT_IMP(a_left_zero_mag, clk, rst_n, out_valid && out_word.left_magnitude == 17'd0,
    out_word.left_out_x == 8'd0 && out_word.left_out_y == 8'd0)
  `ASDZ_ASSERT_NXT(a_valid_from_chain, clk, rst_n, en && vld_r[NSTG-1], out_valid)

endmodule

### hdl/asdz_lane.sv
// ----------------------------------------------------------------------------
// asdz_lane
// Pipelined deadzone scaler for one stick, one result bit per root/quotient stage
// ----------------------------------------------------------------------------
module asdz_lane (
  input  logic               clk,
  input  logic               en,
  input  logic signed [15:0] raw_x,
  input  logic signed [15:0] raw_y,
  input  logic [14:0]        dz,
  input  logic               radial,
  output logic signed [7:0]  out_x,
  output logic signed [7:0]  out_y,
  output logic [16:0]        mag
);

  localparam int NSTG   = asdz_pkg::LANE_STAGES;
  localparam int S_RT0  = 3;
  localparam int S_NORM = S_RT0 + asdz_pkg::ROOT_BITS;
  localparam int S_DV0  = S_NORM + 1;
  localparam int S_MUL  = S_DV0 + asdz_pkg::NORM_BITS;
  localparam int S_SAT  = S_MUL + 1;
  localparam int S_AX0  = S_SAT + 1;
  localparam logic [22:0] LIM = 23'(asdz_pkg::AXIS_MAX * 256);

  typedef struct packed {
    logic        zero;
    logic        neg_x;
    logic        neg_y;
    logic        kill_x;
    logic        kill_y;
    logic        full;
    logic [14:0] ax;
    logic [14:0] ay;
    logic [48:0] acc;
    logic [32:0] accy;
    logic [23:0] root;
    logic [16:0] n;
    logic [6:0]  qx;
    logic [6:0]  qy;
    logic        sat_x;
    logic        sat_y;
  } stg_t;

  stg_t pipe_r [NSTG];
  stg_t pipe_nxt [NSTG];

  logic [22:0] den;
  assign den = {15'(asdz_pkg::AXIS_MAX) - dz, 8'd0};

  // input stage: deadzone test, clamp, magnitudes
  always_comb begin
    logic [16:0] sx, sy, arx, ary, dz17;
    sx   = {raw_x[15], raw_x};
    sy   = {raw_y[15], raw_y};
    arx  = raw_x[15] ? 17'(17'd0 - sx) : sx;
    ary  = raw_y[15] ? 17'(17'd0 - sy) : sy;
    dz17 = {2'd0, dz};
    pipe_nxt[0]        = '0;
    pipe_nxt[0].zero   = (arx < dz17) && (ary < dz17);
    pipe_nxt[0].neg_x  = raw_x[15];
    pipe_nxt[0].neg_y  = raw_y[15];
    pipe_nxt[0].kill_x = !radial && (arx < dz17);
    pipe_nxt[0].kill_y = !radial && (ary < dz17);
    pipe_nxt[0].full   = (dz == 15'(asdz_pkg::AXIS_MAX));
    pipe_nxt[0].ax     = (arx > 17'(asdz_pkg::AXIS_MAX)) ? 15'(asdz_pkg::AXIS_MAX) : arx[14:0];
    pipe_nxt[0].ay     = (ary > 17'(asdz_pkg::AXIS_MAX)) ? 15'(asdz_pkg::AXIS_MAX) : ary[14:0];
  end

  // squares
  always_comb begin
    pipe_nxt[1]      = pipe_r[0];
    pipe_nxt[1].acc  = 49'({15'd0, pipe_r[0].ax} * {15'd0, pipe_r[0].ax});
    pipe_nxt[1].accy = 33'({15'd0, pipe_r[0].ay} * {15'd0, pipe_r[0].ay});
  end

  // radius squared with 16 fraction bits
  always_comb begin
    logic [30:0] sum;
    sum = {1'b0, pipe_r[1].acc[29:0]} + {1'b0, pipe_r[1].accy[29:0]};
    pipe_nxt[2]      = pipe_r[1];
    pipe_nxt[2].acc  = {2'd0, sum, 16'd0};
    pipe_nxt[2].root = '0;
  end

  // square root, one result bit per stage
  for (genvar k = 0; k < asdz_pkg::ROOT_BITS; k++) begin : g_root
    localparam int I = asdz_pkg::ROOT_BITS - 1 - k;
    always_comb begin
      logic [48:0] inc;
      inc = ({25'd0, pipe_r[S_RT0+k-1].root} << (I + 1)) | (49'd1 << (2 * I));
      pipe_nxt[S_RT0+k] = pipe_r[S_RT0+k-1];
      if (pipe_r[S_RT0+k-1].acc >= inc) begin
        pipe_nxt[S_RT0+k].acc     = pipe_r[S_RT0+k-1].acc - inc;
        pipe_nxt[S_RT0+k].root[I] = 1'b1;
      end
    end
  end

  // distance past the deadzone
  always_comb begin
    logic [23:0] m;
    logic [22:0] lim, lo, num;
    m   = pipe_r[S_NORM-1].root;
    lim = (m > {1'b0, LIM}) ? LIM : m[22:0];
    lo  = {dz, 8'd0};
    num = (lim > lo) ? 23'(lim - lo) : 23'd0;
    pipe_nxt[S_NORM]      = pipe_r[S_NORM-1];
    pipe_nxt[S_NORM].zero = pipe_r[S_NORM-1].zero || (m == 24'd0);
    pipe_nxt[S_NORM].acc  = {26'd0, num};
    pipe_nxt[S_NORM].n    = '0;
  end

  // normalize: one quotient bit per stage
  for (genvar k = 0; k < asdz_pkg::NORM_BITS; k++) begin : g_norm
    localparam int J = asdz_pkg::NORM_BITS - 1 - k;
    always_comb begin
      logic [23:0] r;
      r = (k == 0) ? pipe_r[S_DV0+k-1].acc[23:0] : {pipe_r[S_DV0+k-1].acc[22:0], 1'b0};
      pipe_nxt[S_DV0+k] = pipe_r[S_DV0+k-1];
      if (r >= {1'b0, den}) begin
        pipe_nxt[S_DV0+k].acc  = {25'd0, 24'(r - {1'b0, den})};
        pipe_nxt[S_DV0+k].n[J] = 1'b1;
      end else begin
        pipe_nxt[S_DV0+k].acc = {25'd0, r};
      end
    end
  end

  // axis times magnitude
  always_comb begin
    logic [16:0] nsel;
    nsel = pipe_r[S_MUL-1].full ? 17'(asdz_pkg::SCALE_ONE) : pipe_r[S_MUL-1].n;
    pipe_nxt[S_MUL]      = pipe_r[S_MUL-1];
    pipe_nxt[S_MUL].n    = nsel;
    pipe_nxt[S_MUL].acc  = 49'({17'd0, pipe_r[S_MUL-1].ax} * {15'd0, nsel});
    pipe_nxt[S_MUL].accy = 33'({17'd0, pipe_r[S_MUL-1].ay} * {15'd0, nsel});
  end

  // saturation when the quotient would pass 127
  always_comb begin
    logic [32:0] d7;
    d7 = {1'b0, pipe_r[S_SAT-1].root, 8'd0};
    pipe_nxt[S_SAT]       = pipe_r[S_SAT-1];
    pipe_nxt[S_SAT].sat_x = (pipe_r[S_SAT-1].acc[32:0] >= d7);
    pipe_nxt[S_SAT].sat_y = (pipe_r[S_SAT-1].accy >= d7);
    pipe_nxt[S_SAT].qx    = '0;
    pipe_nxt[S_SAT].qy    = '0;
  end

  // axis quotient by twice the radius, one bit per stage
  for (genvar k = 0; k < asdz_pkg::AXQ_BITS; k++) begin : g_axis
    localparam int J = asdz_pkg::AXQ_BITS - 1 - k;
    always_comb begin
      logic [32:0] dj;
      dj = {8'd0, pipe_r[S_AX0+k-1].root, 1'b0} << J;
      pipe_nxt[S_AX0+k] = pipe_r[S_AX0+k-1];
      if (pipe_r[S_AX0+k-1].acc[32:0] >= dj) begin
        pipe_nxt[S_AX0+k].acc   = {16'd0, 33'(pipe_r[S_AX0+k-1].acc[32:0] - dj)};
        pipe_nxt[S_AX0+k].qx[J] = 1'b1;
      end
      if (pipe_r[S_AX0+k-1].accy >= dj) begin
        pipe_nxt[S_AX0+k].accy  = 33'(pipe_r[S_AX0+k-1].accy - dj);
        pipe_nxt[S_AX0+k].qy[J] = 1'b1;
      end
    end
  end

  // stage registers, held while the output stalls
  always_ff @(posedge clk) begin
    if (en) begin
      pipe_r <= pipe_nxt;
    end
  end

  // sign, limit and zeroing of the last stage
  always_comb begin
    logic [6:0] mx, my;
    mx = pipe_r[NSTG-1].sat_x ? 7'(asdz_pkg::OUT_MAX) : pipe_r[NSTG-1].qx;
    my = pipe_r[NSTG-1].sat_y ? 7'(asdz_pkg::OUT_MAX) : pipe_r[NSTG-1].qy;
    if (pipe_r[NSTG-1].zero || pipe_r[NSTG-1].kill_x) begin
      out_x = '0;
    end else begin
      out_x = pipe_r[NSTG-1].neg_x ? 8'(8'd0 - {1'b0, mx}) : {1'b0, mx};
    end
    if (pipe_r[NSTG-1].zero || pipe_r[NSTG-1].kill_y) begin
      out_y = '0;
    end else begin
      out_y = pipe_r[NSTG-1].neg_y ? 8'(8'd0 - {1'b0, my}) : {1'b0, my};
    end
    mag = pipe_r[NSTG-1].zero ? 17'd0 : pipe_r[NSTG-1].n;
  end

endmodule

### tb/sv/analog_stick_deadzone_scaler_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// analog_stick_deadzone_scaler_test
// Self-checking bench for the two-stick deadzone scaler: directed corner
// words, then random words under several idle/stall mixes and deadzone and
// mode settings, every result checked field by field against a predictor.
// ----------------------------------------------------------------------------
module analog_stick_deadzone_scaler_test;

  localparam int LATENCY = 54;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  asdz_pkg::in_word_t  in_word;
  logic      out_valid;
  logic      out_stall;
  asdz_pkg::out_word_t out_word;
  logic      cfg_wr_en;
  logic [1:0]  cfg_index;
  logic [14:0] cfg_data;

  int error_count;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_off_cycles;
  int words_sent;

  analog_stick_deadzone_scaler u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // mismatch report
  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // integer square root, bit by bit
  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // one scaled axis: magnitude times n over 2m, saturated, signed
  function automatic logic signed [7:0] axis_scale(input int c, input longint unsigned n,
                                                   input longint unsigned m);
    longint unsigned q;
    int v;
    q = (longint'(c < 0 ? -c : c) * n) / (2 * m);
    if (q > asdz_pkg::OUT_MAX) q = asdz_pkg::OUT_MAX;
    v = int'(q);
    if (c < 0) v = -v;
    return v[7:0];
  endfunction

  // one stick through deadzone, radius, normalize and scaling
  task automatic stick_predict(input logic signed [15:0] rx, input logic signed [15:0] ry,
                               input int dz, input bit radial,
                               output logic signed [7:0] ox, output logic signed [7:0] oy,
                               output logic [16:0] mag);
    int ax, ay, xc, yc;
    longint unsigned m, lim, n, lo, num;
    ox = 0; oy = 0; mag = 0;
    ax = rx < 0 ? -int'(rx) : int'(rx);
    ay = ry < 0 ? -int'(ry) : int'(ry);
    if (ax < dz && ay < dz) return;
    xc = rx < -asdz_pkg::AXIS_MAX ? -asdz_pkg::AXIS_MAX : int'(rx);
    yc = ry < -asdz_pkg::AXIS_MAX ? -asdz_pkg::AXIS_MAX : int'(ry);
    m = int_sqrt((longint'(xc) * xc + longint'(yc) * yc) << 16);
    if (m == 0) return;
    lim = m < asdz_pkg::AXIS_MAX * 256 ? m : asdz_pkg::AXIS_MAX * 256;
    if (dz >= asdz_pkg::AXIS_MAX) begin
      n = asdz_pkg::SCALE_ONE;
    end else begin
      lo = dz * 256;
      num = lim > lo ? lim - lo : 0;
      n = (num * asdz_pkg::SCALE_ONE) / ((asdz_pkg::AXIS_MAX - dz) * 256);
      if (n > asdz_pkg::SCALE_ONE) n = asdz_pkg::SCALE_ONE;
    end
    if (!(!radial && ax < dz)) ox = axis_scale(xc, n, m);
    if (!(!radial && ay < dz)) oy = axis_scale(yc, n, m);
    mag = n[16:0];
  endtask

  // scoreboard: predicts each accepted word, checks results in order
  class stick_scoreboard;
    int dz_left, dz_right;
    bit radial_left, radial_right;
    asdz_pkg::out_word_t pending[$];
    int checked;

    function void set_reg(input logic [1:0] idx, input logic [14:0] val);
      case (idx)
        asdz_pkg::CFG_DZ_LEFT:      dz_left = val;
        asdz_pkg::CFG_DZ_RIGHT:     dz_right = val;
        asdz_pkg::CFG_RADIAL_LEFT:  radial_left = val[0];
        asdz_pkg::CFG_RADIAL_RIGHT: radial_right = val[0];
      endcase
    endfunction

    task note_input(input asdz_pkg::in_word_t w);
      asdz_pkg::out_word_t e;
      stick_predict(w.left_raw_x, w.left_raw_y, dz_left, radial_left,
                    e.left_out_x, e.left_out_y, e.left_magnitude);
      stick_predict(w.right_raw_x, w.right_raw_y, dz_right, radial_right,
                    e.right_out_x, e.right_out_y, e.right_magnitude);
      pending.push_back(e);
    endtask

    task check_result(input asdz_pkg::out_word_t r);
      asdz_pkg::out_word_t e;
      if (pending.size() == 0) begin
        report("unexpected word", 0, 0);
        return;
      end
      e = pending.pop_front();
      checked++;
      if (r.left_out_x !== e.left_out_x) report("left_out_x", r.left_out_x, e.left_out_x);
      if (r.left_out_y !== e.left_out_y) report("left_out_y", r.left_out_y, e.left_out_y);
      if (r.right_out_x !== e.right_out_x)
        report("right_out_x", r.right_out_x, e.right_out_x);
      if (r.right_out_y !== e.right_out_y)
        report("right_out_y", r.right_out_y, e.right_out_y);
      if (r.left_magnitude !== e.left_magnitude)
        report("left_magnitude", r.left_magnitude, e.left_magnitude);
      if (r.right_magnitude !== e.right_magnitude)
        report("right_magnitude", r.right_magnitude, e.right_magnitude);
    endtask
  endclass

  stick_scoreboard board;

  // clock
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // input and output sampling at the rising edge
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) board.note_input(in_word);
    if (rst_n && out_valid && !out_stall) board.check_result(out_word);
  end

  // receiver stall, with optional long hold-off
  initial begin
    out_stall = 0;
    forever begin
      @(negedge clk);
      if (hold_off_cycles > 0) begin
        out_stall <= 1;
        hold_off_cycles--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [14:0] val);
    @(negedge clk);
    cfg_wr_en <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    board.set_reg(idx, val);
    @(negedge clk);
    cfg_wr_en <= 0;
  endtask

  task automatic set_all(input int dzl, input int dzr, input bit rl, input bit rr);
    write_reg(asdz_pkg::CFG_DZ_LEFT, dzl[14:0]);
    write_reg(asdz_pkg::CFG_DZ_RIGHT, dzr[14:0]);
    write_reg(asdz_pkg::CFG_RADIAL_LEFT, {14'd0, rl});
    write_reg(asdz_pkg::CFG_RADIAL_RIGHT, {14'd0, rr});
  endtask

  // offer one word, hold until accepted; caller is at a falling edge
  // valid stays up after acceptance so the next word can follow directly
  task automatic send_word(input asdz_pkg::in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    in_word <= w;
    do @(posedge clk); while (in_stall);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic drain;
    in_valid <= 0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  function automatic logic [15:0] rand_axis(input int dz);
    case ($urandom_range(5))
      0: return 16'($urandom_range(65535));
      1: return 16'($signed($urandom_range(2 * dz + 2)) - dz - 1);
      2: return $urandom_range(1) ? 16'h8000 : 16'h7fff;
      3: return 16'($signed($urandom_range(20)) - 10);
      default: return 16'($signed($urandom_range(65535)) - 32768);
    endcase
  endfunction

  function automatic asdz_pkg::in_word_t rand_word(input int dzl, input int dzr);
    asdz_pkg::in_word_t w;
    w.left_raw_x = rand_axis(dzl);
    w.left_raw_y = rand_axis(dzl);
    w.right_raw_x = rand_axis(dzr);
    w.right_raw_y = rand_axis(dzr);
    return w;
  endfunction

  task automatic random_phase(input int count, input int idle, input int stall,
                              input int dzl, input int dzr, input bit rl, input bit rr);
    set_all(dzl, dzr, rl, rr);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    repeat (count) send_word(rand_word(dzl, dzr));
    drain();
  endtask

  // stimulus
  initial begin
    logic [15:0] corner [8];
    board = new();
    rst_n = 0;
    in_valid = 0;
    in_word = '0;
    cfg_wr_en = 0;
    cfg_index = asdz_pkg::CFG_DZ_LEFT;
    cfg_data = '0;
    error_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_cycles = 0;
    words_sent = 0;
    board.dz_left = asdz_pkg::DZ_LEFT_RST;
    board.dz_right = asdz_pkg::DZ_RIGHT_RST;
    board.radial_left = 1;
    board.radial_right = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: reset defaults, corners, centered with zero deadzone, full deadzone
    corner = '{16'h8000, 16'h8001, 16'h7fff, 16'h0000, 16'h0001, 16'hffff,
               16'd7849, 16'd8688};
    for (int i = 0; i < 8; i++)
      send_word('{corner[i], corner[7 - i], corner[(i + 3) % 8], corner[(i + 5) % 8]});
    drain();
    set_all(0, 0, 0, 1);
    send_word('0);
    send_word('{16'h8000, 16'h8000, 16'h0001, 16'h0000});
    send_word('{16'h7fff, 16'h7fff, 16'hffff, 16'h0003});
    drain();
    set_all(32767, 32766, 1, 0);
    send_word('{16'h8000, 16'h0000, 16'h7ffe, 16'h0000});
    send_word('{16'h7fff, 16'h1234, 16'h7fff, 16'h8000});
    send_word('{16'h7ffe, 16'h7ffe, 16'h0100, 16'h7ffe});
    drain();

    // long receiver hold-off while the sender keeps offering
    set_all(7849, 8689, 1, 0);
    hold_off_cycles = 3 * LATENCY;
    repeat (90) send_word(rand_word(7849, 8689));
    drain();

    random_phase(100, 0, 0, 7849, 8689, 1, 0);
    random_phase(100, 57, 0, 0, 32767, 0, 1);
    random_phase(100, 0, 57, 32766, 1, 1, 1);
    random_phase(100, 22, 22, $urandom_range(32767), $urandom_range(32767), 0, 0);

    $display("covered %0d words, %0d results checked, deadzones 0..32767, both modes",
             words_sent, board.checked);
    if (error_count == 0)
      $display("[analog_stick_deadzone_scaler] OK");
    else
      $display("[analog_stick_deadzone_scaler] ERROR");
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("[analog_stick_deadzone_scaler] ERROR");
    $finish;
  end
endmodule
